// File: rtl/isotp_pkg.sv
// ----------------------------------------------------------------------------
// isotp_pkg
// Types and constants shared by the ISO-TP receive reassembler modules.
// ----------------------------------------------------------------------------
package isotp_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FLOW = 2'd1,
    KIND_SEQ  = 2'd2,
    KIND_TYPE = 2'd3
  } kind_e;

  // Protocol control frame types (upper nibble of the PCI byte)
  localparam logic [3:0] PCI_SINGLE = 4'd0;
  localparam logic [3:0] PCI_FIRST  = 4'd1;
  localparam logic [3:0] PCI_CONSEC = 4'd2;
  localparam logic [3:0] PCI_FLOW   = 4'd3;

  localparam logic [3:0] MAX_FRAME_LEN = 4'd8;

  localparam int unsigned JOB_QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W          = $clog2(JOB_QUEUE_DEPTH);

  // One classified frame, waiting to be emitted as results
  typedef struct packed {
    logic [7:0][7:0] data;      // frame bytes
    logic [2:0]      start;     // first payload byte position
    logic [2:0]      count;     // payload bytes to emit
    logic [2:0]      total;     // results to emit (payload plus tail)
    logic            msg_end;   // last payload byte completes the message
    kind_e           tail_kind; // kind of the trailing non-data result
  } job_t;

endpackage

// File: rtl/isotp_if.sv
// ----------------------------------------------------------------------------
// isotp_if
// Valid/ready channels for received CAN frames and reassembled results.
// ----------------------------------------------------------------------------
interface isotp_frame_if;
  logic       valid;
  logic       ready;
  logic [3:0] frame_length;
  logic [7:0] data_0;
  logic [7:0] data_1;
  logic [7:0] data_2;
  logic [7:0] data_3;
  logic [7:0] data_4;
  logic [7:0] data_5;
  logic [7:0] data_6;
  logic [7:0] data_7;

  modport source (
    output valid, frame_length, data_0, data_1, data_2, data_3,
           data_4, data_5, data_6, data_7,
    input  ready
  );
  modport sink (
    input  valid, frame_length, data_0, data_1, data_2, data_3,
           data_4, data_5, data_6, data_7,
    output ready
  );
endinterface

interface isotp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       message_end;
  logic       last;

  modport source (
    output valid, kind, payload_byte, message_end, last,
    input  ready
  );
  modport sink (
    input  valid, kind, payload_byte, message_end, last,
    output ready
  );
endinterface

// File: rtl/isotp_front.sv
// ----------------------------------------------------------------------------
// isotp_front
// Accepts frames, decodes the PCI byte, tracks message state and builds jobs.
// ----------------------------------------------------------------------------
module isotp_front import isotp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  isotp_frame_if.sink         frame_i,
  output logic                job_valid_o,
  output job_t                job_o,
  input  logic                job_ready_i
);

  logic        off_q;
  logic [11:0] br_q, br_d;
  logic [3:0]  es_q, es_d;

  logic        accept;
  logic        too_short;
  logic [3:0]  len_c;
  logic [3:0]  present;
  logic [7:0]  pci;
  logic [7:0]  nxt;
  logic [3:0]  frame_type;
  logic [3:0]  nib;
  logic [2:0]  room_ff;
  logic [2:0]  room_cf;
  logic [11:0] first_len;

  assign frame_i.ready = job_ready_i;
  assign accept        = frame_i.valid && frame_i.ready;

  assign len_c     = (frame_i.frame_length > MAX_FRAME_LEN) ? MAX_FRAME_LEN
                                                           : frame_i.frame_length;
  assign too_short = len_c < (4'd1 + {3'b000, off_q});
  assign present   = len_c - 4'd1 - {3'b000, off_q};
  assign pci       = off_q ? frame_i.data_1 : frame_i.data_0;
  assign nxt       = off_q ? frame_i.data_2 : frame_i.data_1;
  assign frame_type = pci[7:4];
  assign nib       = pci[3:0];
  assign room_ff   = 3'd6 - {2'b00, off_q};
  assign room_cf   = 3'd7 - {2'b00, off_q};
  assign first_len = {nib, nxt};

  always_comb begin
    job_o.data      = {frame_i.data_7, frame_i.data_6, frame_i.data_5, frame_i.data_4,
                       frame_i.data_3, frame_i.data_2, frame_i.data_1, frame_i.data_0};
    job_o.start     = 3'd0;
    job_o.count     = 3'd0;
    job_o.total     = 3'd0;
    job_o.msg_end   = 1'b0;
    job_o.tail_kind = KIND_DATA;
    br_d            = br_q;
    es_d            = es_q;
    case (frame_type)
      PCI_SINGLE: begin
        job_o.count   = (nib < present) ? nib[2:0] : present[2:0];
        job_o.start   = {2'b00, off_q} + 3'd1;
        job_o.total   = job_o.count;
        job_o.msg_end = 1'b1;
        br_d          = 12'd0;
      end
      PCI_FIRST: begin
        job_o.count     = (first_len < {9'd0, room_ff}) ? first_len[2:0] : room_ff;
        job_o.start     = {2'b00, off_q} + 3'd2;
        job_o.msg_end   = first_len <= {9'd0, room_ff};
        job_o.tail_kind = KIND_FLOW;
        job_o.total     = job_o.count + 3'd1;
        br_d            = first_len - {9'd0, job_o.count};
        es_d            = 4'd1;
      end
      PCI_CONSEC: begin
        if (nib != es_q) begin
          job_o.tail_kind = KIND_SEQ;
          job_o.total     = 3'd1;
        end else begin
          job_o.count   = (br_q < {9'd0, room_cf}) ? br_q[2:0] : room_cf;
          job_o.start   = {2'b00, off_q} + 3'd1;
          job_o.msg_end = br_q <= {9'd0, room_cf};
          job_o.total   = job_o.count;
          br_d          = br_q - {9'd0, job_o.count};
          es_d          = es_q + 4'd1;
        end
      end
      PCI_FLOW: begin
        // flow control from the peer: nothing to emit
      end
      default: begin
        job_o.tail_kind = KIND_TYPE;
        job_o.total     = 3'd1;
      end
    endcase
  end

  assign job_valid_o = accept && !too_short && (job_o.total != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= 1'b0;
      br_q  <= 12'd0;
      es_q  <= 4'd0;
    end else begin
      if (cfg_we_i) begin
        off_q <= cfg_wdata_i;
      end
      if (accept && !too_short) begin
        br_q <= br_d;
        es_q <= es_d;
      end
    end
  end

endmodule

// File: rtl/isotp_fifo.sv
// ----------------------------------------------------------------------------
// isotp_fifo
// Short job queue between the frame decoder and the result emitter.
// ----------------------------------------------------------------------------
module isotp_fifo import isotp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  job_t              mem_q [JOB_QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   fill_q;
  logic              do_push, do_pop;

  assign push_ready_o = fill_q != (QPTR_W+1)'(JOB_QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/isotp_back.sv
// ----------------------------------------------------------------------------
// isotp_back
// Walks one job per frame and emits its results through an output register.
// ----------------------------------------------------------------------------
module isotp_back import isotp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  job_t           job_i,
  isotp_result_if.source result_o
);

  logic [2:0] k_q, k_d;
  logic       out_valid_q;
  kind_e      kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic       end_q, end_d;
  logic       last_q, last_d;

  logic       load_en;
  logic       emit;
  logic       is_data;
  logic       is_last;
  logic [2:0] idx;

  assign load_en = !out_valid_q || result_o.ready;
  assign emit    = job_valid_i && load_en;
  assign is_data = k_q < job_i.count;
  assign is_last = k_q == (job_i.total - 3'd1);
  assign idx     = job_i.start + k_q;

  // pop the job once its final result enters the output register
  assign job_ready_o = emit && is_last;

  always_comb begin
    kind_d = is_data ? KIND_DATA : job_i.tail_kind;
    byte_d = is_data ? job_i.data[idx] : 8'd0;
    end_d  = is_data && (k_q == (job_i.count - 3'd1)) && job_i.msg_end;
    last_d = is_last;
    k_d    = k_q;
    if (emit) begin
      k_d = is_last ? 3'd0 : k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      end_q  <= end_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (load_en) begin
        out_valid_q <= job_valid_i;
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.kind         = kind_q;
  assign result_o.payload_byte = byte_q;
  assign result_o.message_end  = end_q;
  assign result_o.last         = last_q;

endmodule

// File: rtl/isotp_receive_reassembler.sv
// ----------------------------------------------------------------------------
// isotp_receive_reassembler
// ISO-TP receive reassembly: CAN frames in, message bytes and events out.
// ----------------------------------------------------------------------------
// A frame is accepted whenever the two-entry job queue has room, and the
// decoder updates its byte counter and sequence number on that accept. The
// emitter drains each queued frame at one result per cycle, while the result
// sink is ready, from its output register; a frame yields up to seven
// results, and a frame that yields none is never queued. Sustained
// throughput is set by the emitter's result count.
module isotp_receive_reassembler import isotp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  isotp_frame_if.sink    frame_i,
  isotp_result_if.source result_o
);

  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  isotp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_i),
    .job_valid_o (push_valid),
    .job_o       (push_job),
    .job_ready_i (push_ready)
  );

  isotp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  isotp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .result_o    (result_o)
  );

  // the decoder only produces a job when the queue can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("job pushed into a full queue");

  // message end only ever marks a payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.message_end) |-> (result_o.kind == KIND_DATA))
    else $error("message end on a non-data result");

  // flow-control and error results always close their frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.kind != KIND_DATA)) |-> result_o.last)
    else $error("non-data result not marked last");

  // a queued job with a popped entry always had at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid |-> (pop_job.total != 3'd0))
    else $error("empty job in queue");

endmodule
